// ===== design/tcpe_pkg.sv =====
`default_nettype none

package tcpe_pkg;

    localparam logic [7:0] TN_IAC      = 8'd255;
    localparam logic [7:0] TN_WILL     = 8'd251;
    localparam logic [7:0] TN_DO       = 8'd253;
    localparam logic [7:0] TN_SB       = 8'd250;
    localparam logic [7:0] TN_SE       = 8'd240;
    localparam logic [7:0] TN_COM_PORT = 8'd44;
    localparam logic [7:0] CODE_BASE   = 8'd100;
    localparam logic [7:0] CODE_LAST   = CODE_BASE + 8'd5;

    localparam logic [3:0] COUNT_MAX   = 4'd15;
    localparam logic [3:0] COUNT_VAL0  = 4'd2;
    localparam logic [3:0] COUNT_VALN  = 4'd5;
    localparam logic [3:0] COUNT_MIN   = 4'd3;
    localparam logic [3:0] COUNT_BAUD  = 4'd6;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_IAC    = 3'd1,
        MODE_SKIP   = 3'd2,
        MODE_SUB    = 3'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_BAUD     = 3'd1,
        KIND_DATASIZE = 3'd2,
        KIND_PARITY   = 3'd3,
        KIND_STOPSIZE = 3'd4,
        KIND_CONTROL  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [3:0]  count;
        logic [7:0]  option;
        logic [7:0]  code;
        logic [31:0] value;
    } sub_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] setting_value;
    } result_t;

    localparam sub_t SUB_CLEAR = '{count: 4'd0, option: 8'd0, code: 8'd0, value: 32'd0};

    function automatic sub_t sub_store(sub_t s, logic [7:0] b);
        sub_t n;
        n = s;
        if (s.count == 4'd0)
        begin
            n.option = b;
        end
        else if (s.count == 4'd1)
        begin
            n.code = b;
        end
        else if (s.count <= COUNT_VALN)
        begin
            n.value = {s.value[23:0], b};
        end
        if (s.count < COUNT_MAX)
        begin
            n.count = s.count + 4'd1;
        end
        return n;
    endfunction

    function automatic result_t sub_finish(sub_t s, logic enable);
        result_t    r;
        logic [3:0] nvals;
        logic [2:0] setting;
        r = '0;
        nvals = s.count - COUNT_VAL0;
        if (nvals > 4'd4)
        begin
            nvals = 4'd4;
        end
        setting = 3'(s.code - CODE_BASE);
        if (enable && s.option == TN_COM_PORT && s.count >= COUNT_MIN
            && s.code > CODE_BASE && s.code <= CODE_LAST)
        begin
            if (setting == KIND_BAUD)
            begin
                if (s.count >= COUNT_BAUD)
                begin
                    r.valid = 1'b1;
                    r.kind = KIND_BAUD;
                    r.setting_value = s.value;
                end
            end
            else
            begin
                r.valid = 1'b1;
                r.kind = setting;
                case (nvals)
                    4'd1:    r.setting_value = {24'd0, s.value[7:0]};
                    4'd2:    r.setting_value = {24'd0, s.value[15:8]};
                    4'd3:    r.setting_value = {24'd0, s.value[23:16]};
                    default: r.setting_value = {24'd0, s.value[31:24]};
                endcase
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tcpe_parser.sv =====
`default_nettype none

module tcpe_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              decode_enable,
    output tcpe_pkg::result_t      result
);
    import tcpe_pkg::*;

    mode_t mode_reg, mode_next;
    logic  saw_iac_reg, saw_iac_next;
    sub_t  sub_reg, sub_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            saw_iac_reg <= 1'b0;
            sub_reg     <= SUB_CLEAR;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            saw_iac_reg <= saw_iac_next;
            sub_reg     <= sub_next;
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        saw_iac_next = saw_iac_reg;
        sub_next     = sub_reg;
        result       = '0;
        unique case (mode_reg)
            MODE_IAC:
            begin
                if (rx_byte == TN_IAC)
                begin
                    mode_next        = MODE_NORMAL;
                    result.valid     = 1'b1;
                    result.kind      = KIND_DATA;
                    result.data_byte = rx_byte;
                end
                else if (rx_byte == TN_WILL || rx_byte == TN_DO)
                begin
                    mode_next = MODE_SKIP;
                end
                else if (rx_byte == TN_SB)
                begin
                    mode_next    = MODE_SUB;
                    saw_iac_next = 1'b0;
                    sub_next     = SUB_CLEAR;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_SKIP:
            begin
                mode_next = MODE_NORMAL;
            end
            MODE_SUB:
            begin
                if (saw_iac_reg)
                begin
                    if (rx_byte == TN_SE)
                    begin
                        saw_iac_next = 1'b0;
                        mode_next    = MODE_NORMAL;
                        result       = sub_finish(sub_reg, decode_enable);
                    end
                    else if (rx_byte == TN_IAC)
                    begin
                        // lone IAC kept as payload, this one may still open IAC SE
                        sub_next = sub_store(sub_reg, TN_IAC);
                    end
                    else
                    begin
                        saw_iac_next = 1'b0;
                        sub_next     = sub_store(sub_store(sub_reg, TN_IAC), rx_byte);
                    end
                end
                else if (rx_byte == TN_IAC)
                begin
                    saw_iac_next = 1'b1;
                end
                else
                begin
                    sub_next = sub_store(sub_reg, rx_byte);
                end
            end
            default:
            begin
                if (rx_byte == TN_IAC)
                begin
                    mode_next = MODE_IAC;
                end
                else
                begin
                    mode_next        = MODE_NORMAL;
                    result.valid     = 1'b1;
                    result.kind      = KIND_DATA;
                    result.data_byte = rx_byte;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/telnet_com_port_escape_parser_top.sv =====
`default_nettype none

// channel  | direction | handshake            | payload
// cfg      | in        | cfg_valid/cfg_ready  | cfg_decode_enable
// in       | in        | in_valid/in_ready    | rx_byte
// out      | out       | out_valid/out_ready  | kind, data_byte, setting_value
//
// One byte per cycle while in_ready is high; a result is registered in the output or skid stage.
// The output register is backed by a skid stage: in_ready drops only while the
// skid stage holds a request, i.e. after two results stall at the output.
// cfg_ready is always high; decode_enable resets to 1.
// Reset (rst_n low, asynchronous) returns the parser to normal data mode.

module telnet_com_port_escape_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_decode_enable,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic [31:0]      setting_value
);
    import tcpe_pkg::*;

    logic    decode_enable_reg;
    logic    accept;
    logic    pop;
    result_t res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_enable_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            decode_enable_reg <= cfg_decode_enable;
        end
    end

    tcpe_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .rx_byte       (rx_byte),
        .decode_enable (decode_enable_reg),
        .result        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && res.valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && res.valid)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign data_byte     = out_reg.data_byte;
    assign setting_value = out_reg.setting_value;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with output register empty");

    a_data_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_DATA) |-> (setting_value == 32'd0))
        else $error("data request carries a setting value");

    a_setting_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_DATA) |-> (data_byte == 8'd0 && kind <= KIND_CONTROL))
        else $error("malformed setting request");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> !skid_valid_reg && out_valid_reg)
        else $error("skid stage failed to drain");

endmodule

`default_nettype wire
